[design/rgbhsv_pkg.sv]
`default_nettype none

package rgbhsv_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_Q_W    = 5;                  // hue offset within a sector is 0..30
    localparam int HUE_NUM_W  = CH_W + HUE_Q_W;
    localparam int SAT_Q_W    = 8;
    localparam int SAT_NUM_W  = CH_W + SAT_Q_W;
    localparam int DIV_STEPS  = SAT_Q_W;            // one quotient bit per stage
    // sort, sector, dividend setup, divide steps, output
    localparam int NUM_STAGES = 2 + 1 + DIV_STEPS + 1;
    localparam int TDATA_W    = 3 * CH_W;

    localparam logic [CH_W-1:0] HUE_BASE_RED      = 8'd0;
    localparam logic [CH_W-1:0] HUE_BASE_RED_WRAP = 8'd180;
    localparam logic [CH_W-1:0] HUE_BASE_GREEN    = 8'd60;
    localparam logic [CH_W-1:0] HUE_BASE_BLUE     = 8'd120;
    localparam logic [CH_W-1:0] HUE_MAX           = 8'd179;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] max;
        logic [CH_W-1:0] min;
        sector_t         sector;
    } sort_stage_t;

    typedef struct packed {
        logic [CH_W-1:0] max;
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] diff;
        logic [CH_W-1:0] base;
        logic            sub;
    } sector_stage_t;

    typedef struct packed {
        logic                 grey;
        logic                 black;
        logic                 sub;
        logic [CH_W-1:0]      base;
        logic [CH_W-1:0]      delta;
        logic [CH_W-1:0]      max;
        logic [HUE_NUM_W-1:0] hue_acc;   // remainder above, dividend then quotient bits below
        logic [SAT_NUM_W-1:0] sat_acc;
    } div_stage_t;

    // one restoring step, remainder bits stay below the divisor
    function automatic logic [HUE_NUM_W-1:0] hue_div_step(
        input logic [HUE_NUM_W-1:0] acc,
        input logic [CH_W-1:0]      divisor
    );
        logic [CH_W:0] trial;
        logic [CH_W:0] rest;
        trial = acc[HUE_NUM_W-1 -: CH_W+1];
        rest  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            return {rest[CH_W-1:0], acc[HUE_Q_W-2:0], 1'b1};
        end
        return {trial[CH_W-1:0], acc[HUE_Q_W-2:0], 1'b0};
    endfunction

    function automatic logic [SAT_NUM_W-1:0] sat_div_step(
        input logic [SAT_NUM_W-1:0] acc,
        input logic [CH_W-1:0]      divisor
    );
        logic [CH_W:0] trial;
        logic [CH_W:0] rest;
        trial = acc[SAT_NUM_W-1 -: CH_W+1];
        rest  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
            return {rest[CH_W-1:0], acc[SAT_Q_W-2:0], 1'b1};
        end
        return {trial[CH_W-1:0], acc[SAT_Q_W-2:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

[design/rgb_to_hsv_pixel.sv]
// throughput: one pixel per cycle while the output is not held, through the
//   12-stage pipeline that resolves one saturation quotient bit in each of its
//   8 divide stages, and one hue quotient bit in each until the five are done
// reset (aresetn low, synchronous) clears the stage valid bits only;
//   data registers are not reset
`default_nettype none

module rgb_to_hsv_pixel
    import rgbhsv_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    input  wire  [TDATA_W-1:0]       s_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic                     m_tvalid,
    input  wire                      m_tready,
    output logic [TDATA_W-1:0]       m_tdata    // hue_half_deg [7:0], saturation [15:8], value [23:16]
);

    localparam int LAST = NUM_STAGES - 1;
    localparam int DIV0 = 2;                      // valid index of the dividend stage

    // stage valid bits and load enables
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stg_en;

    // a stage loads when it is empty or its content moves on this cycle,
    // so bubbles collapse while the output holds
    assign stg_en[LAST] = !vld_reg[LAST] || m_tready;
    for (genvar i = 0; i < LAST; i++) begin : g_en
        assign stg_en[i] = !vld_reg[i] || stg_en[i+1];
    end

    assign s_tready = stg_en[0];
    assign m_tvalid = vld_reg[LAST];

    always_comb begin
        vld_next = vld_reg;
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (stg_en[i]) begin
                vld_next[i] = (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: max, min and hue sector (red wins ties, then green)
    sort_stage_t sort_reg;
    sort_stage_t sort_next;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;

    assign in_blue  = s_tdata[CH_W-1:0];
    assign in_green = s_tdata[2*CH_W-1:CH_W];
    assign in_red   = s_tdata[3*CH_W-1:2*CH_W];

    always_comb begin
        sort_next.blue  = in_blue;
        sort_next.green = in_green;
        sort_next.red   = in_red;
        if (in_red >= in_green && in_red >= in_blue) begin
            sort_next.sector = SECTOR_RED;
            sort_next.max    = in_red;
        end else if (in_green >= in_blue) begin
            sort_next.sector = SECTOR_GREEN;
            sort_next.max    = in_green;
        end else begin
            sort_next.sector = SECTOR_BLUE;
            sort_next.max    = in_blue;
        end
        if (in_red <= in_green && in_red <= in_blue) begin
            sort_next.min = in_red;
        end else if (in_green <= in_blue) begin
            sort_next.min = in_green;
        end else begin
            sort_next.min = in_blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            sort_reg <= sort_next;
        end
    end

    // stage 2: delta, and the signed channel difference inside the sector
    // as a magnitude plus a subtract flag
    sector_stage_t sec_reg;
    sector_stage_t sec_next;

    always_comb begin
        sec_next.max   = sort_reg.max;
        sec_next.delta = sort_reg.max - sort_reg.min;
        case (sort_reg.sector)
            SECTOR_RED: begin
                // negative red hue wraps by a full turn
                sec_next.sub  = sort_reg.green < sort_reg.blue;
                sec_next.diff = sec_next.sub ? sort_reg.blue - sort_reg.green
                                             : sort_reg.green - sort_reg.blue;
                sec_next.base = sec_next.sub ? HUE_BASE_RED_WRAP : HUE_BASE_RED;
            end
            SECTOR_GREEN: begin
                sec_next.sub  = sort_reg.blue < sort_reg.red;
                sec_next.diff = sec_next.sub ? sort_reg.red - sort_reg.blue
                                             : sort_reg.blue - sort_reg.red;
                sec_next.base = HUE_BASE_GREEN;
            end
            SECTOR_BLUE: begin
                sec_next.sub  = sort_reg.red < sort_reg.green;
                sec_next.diff = sec_next.sub ? sort_reg.green - sort_reg.red
                                             : sort_reg.red - sort_reg.green;
                sec_next.base = HUE_BASE_BLUE;
            end
            default: begin
                sec_next.sub  = 1'b0;
                sec_next.diff = '0;
                sec_next.base = HUE_BASE_RED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            sec_reg <= sec_next;
        end
    end

    // stage 3: dividends
    //   hue offset = floor(30*diff/delta), or ceil of it when subtracting,
    //   done as floor((30*diff + delta - 1)/delta)
    //   saturation = floor(255*delta/max)
    div_stage_t div_reg [0:DIV_STEPS];
    div_stage_t div_first;
    logic [HUE_NUM_W-1:0] diff_x30;
    logic [HUE_NUM_W-1:0] round_up;

    assign diff_x30 = (HUE_NUM_W'(sec_reg.diff) << 5) - (HUE_NUM_W'(sec_reg.diff) << 1);
    assign round_up = sec_reg.sub ? {{(HUE_NUM_W-CH_W){1'b0}}, sec_reg.delta - 1'b1} : '0;

    always_comb begin
        div_first.grey    = (sec_reg.delta == '0);
        div_first.black   = (sec_reg.max == '0);
        div_first.sub     = sec_reg.sub;
        div_first.base    = sec_reg.base;
        div_first.delta   = sec_reg.delta;
        div_first.max     = sec_reg.max;
        div_first.hue_acc = div_first.grey ? '0 : diff_x30 + round_up;
        div_first.sat_acc = {sec_reg.delta, {SAT_Q_W{1'b0}}}
                          - {{SAT_Q_W{1'b0}}, sec_reg.delta};
    end

    always_ff @(posedge aclk) begin
        if (stg_en[DIV0]) begin
            div_reg[0] <= div_first;
        end
    end

    // divide stages: one quotient bit of each divider per stage,
    // the hue divider finishes after its five bits and rides along
    div_stage_t div_next [1:DIV_STEPS];

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        always_comb begin
            div_next[k]         = div_reg[k-1];
            div_next[k].sat_acc = sat_div_step(div_reg[k-1].sat_acc, div_reg[k-1].max);
            if (k <= HUE_Q_W) begin
                div_next[k].hue_acc = hue_div_step(div_reg[k-1].hue_acc,
                                                   div_reg[k-1].delta);
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_en[DIV0+k]) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // output stage: sector base plus or minus the offset, special cases forced
    logic [CH_W-1:0] hue_reg;
    logic [CH_W-1:0] hue_next;
    logic [CH_W-1:0] sat_reg;
    logic [CH_W-1:0] sat_next;
    logic [CH_W-1:0] value_reg;
    logic [CH_W-1:0] hue_ofs;

    assign hue_ofs = {{(CH_W-HUE_Q_W){1'b0}}, div_reg[DIV_STEPS].hue_acc[HUE_Q_W-1:0]};

    always_comb begin
        if (div_reg[DIV_STEPS].grey) begin
            hue_next = '0;
        end else if (div_reg[DIV_STEPS].sub) begin
            hue_next = div_reg[DIV_STEPS].base - hue_ofs;
        end else begin
            hue_next = div_reg[DIV_STEPS].base + hue_ofs;
        end
        sat_next = div_reg[DIV_STEPS].black ? '0 : div_reg[DIV_STEPS].sat_acc[SAT_Q_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[LAST]) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= div_reg[DIV_STEPS].max;
        end
    end

    assign m_tdata = {value_reg, sat_reg, hue_reg};

    // hue stays below a full turn, at most HUE_MAX
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hue_reg <= HUE_MAX)
        else $error("hue out of range");

    // a colored pixel always has some saturation
    a_hue_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hue_reg != '0) |-> sat_reg != '0)
        else $error("nonzero hue with zero saturation");

    // black pixel gives zero hue and saturation
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && value_reg == '0) |-> (sat_reg == '0 && hue_reg == '0))
        else $error("black pixel with nonzero hue or saturation");

    // input back-pressure only while the output is held
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule

`default_nettype wire

[tb/rgb_to_hsv_pixel_tb.sv]
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_tb;
    import rgbhsv_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PERCENT = 32;
    localparam int STALL_CYCLES = 300;

    // one converted pixel, fields as they sit in m_tdata
    typedef struct packed {
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] hue_half_deg;
    } hsv_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;   // blue [7:0], green [15:8], red [23:16]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;         // hue_half_deg [7:0], saturation [15:8], value [23:16]

    // converted pixels still owed by the block, oldest first
    hsv_t pending_hsv[$];
    int   mismatch_count = 0;

    // both sides stop idling while this is set
    bit   steady_stream  = 1'b0;
    // asks the receiver process for one long hold-off
    bit   stall_request  = 1'b0;

    rgb_to_hsv_pixel dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // hue in two-degree units, saturation and value of one pixel, exact integer math
    function automatic hsv_t predict_hsv(input logic [CH_W-1:0] blue,
                                         input logic [CH_W-1:0] green,
                                         input logic [CH_W-1:0] red);
        hsv_t res;
        int   b;
        int   g;
        int   r;
        int   top;
        int   bottom;
        int   spread;
        int   num;
        int   hue;
        int   sat;
        b      = blue;
        g      = green;
        r      = red;
        top    = b;
        bottom = b;
        if (g > top) top = g;
        if (r > top) top = r;
        if (g < bottom) bottom = g;
        if (r < bottom) bottom = r;
        spread = top - bottom;

        // red sector wins ties over green, green over blue
        if (spread == 0) begin
            hue = 0;                                   // grey or black pixel
        end else begin
            if (top == r) begin
                if (g >= b) begin
                    num = 30 * (g - b);
                end else begin
                    num = 180 * spread + 30 * (g - b); // negative hue wrapped by a full turn
                end
            end else if (top == g) begin
                num = 60 * spread + 30 * (b - r);
            end else begin
                num = 120 * spread + 30 * (r - g);
            end
            hue = num / spread;
        end

        sat = (top == 0) ? 0 : (255 * spread) / top;

        res.hue_half_deg = CH_W'(hue);
        res.saturation   = CH_W'(sat);
        res.value        = CH_W'(top);
        return res;
    endfunction

    // offers one pixel, with random idle cycles first, and waits for its transaction
    task automatic send_pixel(input logic [CH_W-1:0] blue,
                              input logic [CH_W-1:0] green,
                              input logic [CH_W-1:0] red);
        hsv_t expected;
        expected = predict_hsv(blue, green, red);
        while (!steady_stream && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {red, green, blue};
        do @(posedge aclk); while (!s_tready);
        pending_hsv.push_back(expected);
    endtask

    // sender goes quiet until every owed result has come out
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_hsv.size() != 0) @(posedge aclk);
    endtask

    // channel value that favors the extremes
    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return CH_W'($urandom_range(3));
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    // random pixel, mostly independent channels, some grey, tied and dim ones
    task automatic send_random_pixel();
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] r;
        b = random_channel();
        g = random_channel();
        r = random_channel();
        case ($urandom_range(9))
            0: begin                                   // grey
                g = b;
                r = b;
            end
            1: begin                                   // two channels tie
                case ($urandom_range(2))
                    0:       g = r;
                    1:       b = r;
                    default: b = g;
                endcase
            end
            2: begin                                   // dim pixel, tiny spread
                b = CH_W'($urandom_range(3));
                g = CH_W'($urandom_range(3));
                r = CH_W'($urandom_range(3));
            end
            default: ;
        endcase
        send_pixel(b, g, r);
    endtask

    // extremes, every sector with both signs of offset, ties, grey and black
    task automatic test_corner_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
        send_pixel(8'd1,   8'd1,   8'd1);     // darkest grey
        send_pixel(8'd0,   8'd0,   8'd255);   // pure red
        send_pixel(8'd0,   8'd255, 8'd0);     // pure green
        send_pixel(8'd255, 8'd0,   8'd0);     // pure blue
        send_pixel(8'd0,   8'd0,   8'd1);     // smallest red
        send_pixel(8'd1,   8'd0,   8'd255);   // red sector, wrapped hue
        send_pixel(8'd255, 8'd0,   8'd255);   // red and blue tie, wrapped
        send_pixel(8'd0,   8'd255, 8'd255);   // red and green tie
        send_pixel(8'd255, 8'd255, 8'd0);     // green and blue tie
        send_pixel(8'd100, 8'd50,  8'd200);   // red max, green below blue
        send_pixel(8'd50,  8'd100, 8'd200);   // red max, green above blue
        send_pixel(8'd150, 8'd220, 8'd10);    // green max, blue above red
        send_pixel(8'd10,  8'd220, 8'd150);   // green max, blue below red
        send_pixel(8'd220, 8'd10,  8'd150);   // blue max, red above green
        send_pixel(8'd220, 8'd150, 8'd10);    // blue max, red below green
        send_pixel(8'd254, 8'd255, 8'd254);   // spread of one at the top
        send_pixel(8'd0,   8'd1,   8'd255);   // red max, near wrap edge
        send_pixel(8'd255, 8'd254, 8'd0);     // blue max, near green edge
        send_pixel(8'hAA,  8'h55,  8'hAA);    // alternating bit patterns
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count) send_random_pixel();
    endtask

    // receiver holds off long enough that the pipeline fills and s_tready drops
    task automatic test_output_stall();
        stall_request = 1'b1;
        repeat (60) send_random_pixel();
    endtask

    // sender waits for the pipeline to empty, then restarts
    task automatic test_drain_pause();
        pause_until_drained();
        repeat (100) send_random_pixel();
    endtask

    // back-to-back transactions on both sides
    task automatic test_steady_stream();
        steady_stream = 1'b1;
        repeat (400) send_random_pixel();
        steady_stream = 1'b0;
    endtask

    // receiver: random ready, one long hold-off on request, none while steady
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left -= 1;
            end else if (steady_stream) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic report_field(input string field, input logic [CH_W-1:0] expected,
                                input logic [CH_W-1:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expected,
                     actual);
            mismatch_count++;
        end
    endtask

    // result checker: every output transaction against the oldest owed result
    always @(posedge aclk) begin
        hsv_t expected;
        hsv_t actual;
        if (aresetn && m_tvalid && m_tready) begin
            actual = m_tdata;
            if (pending_hsv.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                expected = pending_hsv.pop_front();
                report_field("hue_half_deg", expected.hue_half_deg, actual.hue_half_deg);
                report_field("saturation", expected.saturation, actual.saturation);
                report_field("value", expected.value, actual.value);
            end
        end
    end

    // sequence of tests
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_corner_pixels();
        test_random_pixels(1200);
        test_output_stall();
        test_drain_pause();
        test_steady_stream();

        // let the pipeline empty, then keep watching for stray results
        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (2 * NUM_STAGES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[rgb_to_hsv_pixel.f]
design/rgbhsv_pkg.sv
design/rgb_to_hsv_pixel.sv
tb/rgb_to_hsv_pixel_tb.sv
